// ===== rtl/espc_pkg.sv =====
// Package: word types and constants for the encoder speed P controller.
`default_nettype none

package espc_pkg;

    typedef struct packed {
        logic        func;
        logic [31:0] now_us;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  pwm_duty;
        logic        drive_forward;
        logic        drive_reverse;
        logic [14:0] measured_speed;
        logic [31:0] pulse_total;
    } t_out_word;

    typedef enum logic [1:0] {
        REG_TARGET  = 2'd0,
        REG_GAIN    = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_DPP     = 2'd3
    } t_reg_idx;

    localparam logic       FUNC_PULSE = 1'b0;

    localparam int         MS_W  = 23;
    localparam int         DVD_W = 42;

    localparam logic [5:0] DIV_A_LAST = 6'd31;
    localparam logic [5:0] DIV_B_LAST = 6'd25;

    localparam logic [MS_W-1:0] MS_PER_S   = 23'd1000;
    localparam logic [14:0]     SPEED_MAX  = 15'd32767;
    localparam logic [23:0]     DEAD_ZONE  = 24'd30;
    localparam logic [23:0]     DUTY_LIMIT = 24'd200;
    localparam logic [7:0]      DUTY_MAX   = 8'd200;

    localparam logic [30:0] TIMEOUT_RST = 31'd100000;
    localparam logic [31:0] DPP_RST     = 32'd65536;

endpackage

`default_nettype wire

// ===== rtl/espc_speed.sv =====
// Bit-serial speed unit: period/1000, then 1000*dist_per_pulse/ms >> 16, saturated.
`default_nettype none

module espc_speed
    import espc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_period,
    input  wire logic [31:0] i_dpp,
    output logic             o_busy,
    output logic             o_done,
    output logic [14:0]      o_speed
);

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_DIVA,
        SP_MID,
        SP_DIVB,
        SP_FIN
    } t_sp_state;

    t_sp_state        r_state;
    logic [MS_W-1:0]  r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [MS_W-1:0]  r_dsr;
    logic [MS_W-1:0]  r_quo;
    logic [5:0]       r_cnt;
    logic             r_ovf;

    logic [MS_W:0]    w_trial;
    logic             w_ge;
    logic [MS_W:0]    w_diff;
    logic [MS_W-1:0]  w_rem;
    logic [DVD_W-1:0] w_dpp_k;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_rem   = w_ge ? w_diff[MS_W-1:0] : w_trial[MS_W-1:0];

    // 1000 = 1024 - 16 - 8
    assign w_dpp_k = {i_dpp, 10'd0} - {6'd0, i_dpp, 4'd0} - {7'd0, i_dpp, 3'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SP_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                SP_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_dvd   <= {i_period, 10'd0};
                        r_dsr   <= MS_PER_S;
                        r_quo   <= '0;
                        r_cnt   <= DIV_A_LAST;
                        r_ovf   <= 1'b0;
                        r_state <= SP_DIVA;
                    end
                end
                SP_DIVA: begin
                    r_rem <= w_rem;
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_quo <= {r_quo[MS_W-2:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= SP_MID;
                    end
                end
                SP_MID: begin
                    if (r_quo == '0) begin
                        r_ovf   <= 1'b1;
                        r_state <= SP_FIN;
                    end else begin
                        r_rem   <= '0;
                        r_dvd   <= w_dpp_k;
                        r_dsr   <= r_quo;
                        r_quo   <= '0;
                        r_cnt   <= DIV_B_LAST;
                        r_state <= SP_DIVB;
                    end
                end
                SP_DIVB: begin
                    r_rem <= w_rem;
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_quo <= {r_quo[MS_W-2:0], w_ge};
                    r_ovf <= r_ovf | r_quo[14];
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= SP_FIN;
                    end
                end
                SP_FIN: begin
                    r_state <= SP_IDLE;
                end
                default: begin
                    r_state <= SP_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != SP_IDLE);
    assign o_done  = (r_state == SP_FIN);
    assign o_speed = r_ovf ? SPEED_MAX : r_quo[14:0];

endmodule

`default_nettype wire

// ===== rtl/encoder_speed_p_controller.sv =====
// Top level: encoder pulse bookkeeping, speed measurement and P drive control.
// Sequence: an accepted word goes to S_CHECK; when speed reads zero, a pulse
// moves on to S_DONE and a control update through S_MULT and S_CTRL to S_DONE.
// Otherwise S_SPEED first waits on the 32-step and 26-step bit-serial
// divisions in espc_speed (only the first under 1 ms). A waiting result does
// not block the next accept. Reset: synchronous active low, clears state and
// loads register defaults (timeout 100000 us, distance per pulse 1.0).
`default_nettype none

module encoder_speed_p_controller
    import espc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_word        o_out_word,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPEED,
        S_MULT,
        S_CTRL,
        S_DONE
    } t_state;

    t_state       r_state;
    logic [15:0]  r_target;
    logic [15:0]  r_gain;
    logic [30:0]  r_timeout;
    logic [31:0]  r_dpp;
    logic [31:0]  r_last;
    logic [31:0]  r_period;
    logic [31:0]  r_counter;
    logic [9:0]   r_drive;
    logic         r_func;
    logic [31:0]  r_now;
    logic [14:0]  r_speed;
    logic         r_neg;
    logic [31:0]  r_prod;
    logic         r_out_valid;
    t_out_word    r_out_word;

    logic         w_in_acc;
    logic [31:0]  w_age;
    logic         w_zero;
    logic         w_spd_start;
    logic         w_spd_busy;
    logic         w_spd_done;
    logic [14:0]  w_spd;
    logic [16:0]  w_err;
    logic [15:0]  w_mag;
    logic [23:0]  w_act;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_age       = r_now - r_last;
    assign w_zero      = (r_period == '0) || (w_age > {1'b0, r_timeout});
    assign w_spd_start = (r_state == S_CHECK) && !w_zero;
    assign w_err       = {r_target[15], r_target} - {2'b00, r_speed};
    assign w_mag       = w_err[16] ? 16'(-w_err) : w_err[15:0];
    assign w_act       = r_prod[31:8];

    espc_speed u_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_spd_start),
        .i_period (r_period),
        .i_dpp    (r_dpp),
        .o_busy   (w_spd_busy),
        .o_done   (w_spd_done),
        .o_speed  (w_spd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_gain    <= '0;
            r_timeout <= TIMEOUT_RST;
            r_dpp     <= DPP_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TARGET:  r_target  <= i_cfg_data[15:0];
                REG_GAIN:    r_gain    <= i_cfg_data[15:0];
                REG_TIMEOUT: r_timeout <= i_cfg_data[30:0];
                REG_DPP:     r_dpp     <= i_cfg_data;
                default:     r_dpp     <= r_dpp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_period    <= '0;
            r_counter   <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func <= i_in_word.func;
                        r_now  <= i_in_word.now_us;
                        if (i_in_word.func == FUNC_PULSE) begin
                            r_period  <= i_in_word.now_us - r_last;
                            r_last    <= i_in_word.now_us;
                            r_counter <= r_counter + 32'd1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_zero) begin
                        r_speed <= '0;
                        r_state <= (r_func == FUNC_PULSE) ? S_DONE : S_MULT;
                    end else begin
                        r_state <= S_SPEED;
                    end
                end
                S_SPEED: begin
                    if (w_spd_done) begin
                        r_speed <= w_spd;
                        r_state <= (r_func == FUNC_PULSE) ? S_DONE : S_MULT;
                    end
                end
                S_MULT: begin
                    r_neg   <= w_err[16];
                    r_prod  <= w_mag * r_gain;
                    r_state <= S_CTRL;
                end
                S_CTRL: begin
                    if (w_act >= DEAD_ZONE) begin
                        r_drive <= {r_neg, !r_neg,
                                    (w_act > DUTY_LIMIT) ? DUTY_MAX : w_act[7:0]};
                    end else begin
                        r_drive <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid                   <= 1'b1;
                        r_out_word.pwm_duty           <= r_drive[7:0];
                        r_out_word.drive_forward      <= r_drive[8];
                        r_out_word.drive_reverse      <= r_drive[9];
                        r_out_word.measured_speed     <= r_speed;
                        r_out_word.pulse_total        <= r_counter;
                        r_state                       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_spd_busy)
        else $error("speed unit busy while accepting words");

    a_pulse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.func == FUNC_PULSE) |=> (r_counter == $past(r_counter) + 32'd1))
        else $error("pulse count not advanced");

    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drive[8] && r_drive[9]))
        else $error("both bridge directions driven");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_drive[8] && !r_drive[9]) |-> (r_drive[7:0] == '0))
        else $error("duty nonzero with bridge off");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive[7:0] <= DUTY_MAX)
        else $error("duty above limit");

endmodule

`default_nettype wire
